FILE: hdl/nearest_timestamp_matcher_assert.svh
// assertion macros for the nearest timestamp matcher checks
`ifndef NEAREST_TIMESTAMP_MATCHER_ASSERT_SVH
`define NEAREST_TIMESTAMP_MATCHER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NTM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define NTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ntm_pkg.sv
// shared types and constants of the nearest timestamp matcher
package ntm_pkg;

	// table size and derived widths
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int STAMP_W  = 40;
	localparam int FRAME_W  = 32;
	localparam int QNUM_W   = 32;
	localparam int CMD_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 40;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 104;

	// request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_MATCH = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAP_EN    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 1'b1;

	// table write request
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [STAMP_W-1:0] stamp;
		logic [FRAME_W-1:0] frame;
	} tbl_wr_t;

	// table read data
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [FRAME_W-1:0] frame;
	} tbl_rd_t;

endpackage

FILE: hdl/ntm_table.sv
// frame table memory: one write port, one registered read port
module ntm_table
	import ntm_pkg::*;
(
	input  logic             clk,
	input  tbl_wr_t          wr,
	input  logic [IDX_W-1:0] rd_addr,
	output tbl_rd_t          rd
);

	logic [STAMP_W-1:0] stamp_mem [TABLE_DEPTH];
	logic [FRAME_W-1:0] frame_mem [TABLE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			stamp_mem[wr.addr] <= wr.stamp;
			frame_mem[wr.addr] <= wr.frame;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd.stamp <= stamp_mem[rd_addr];
		rd.frame <= frame_mem[rd_addr];
	end

endmodule

FILE: hdl/nearest_timestamp_matcher.sv
// nearest timestamp matcher top level: table control, binary search sequencer, output register
//
//  channel  dir  handshake                fields
//  s_*      in   s_tvalid/s_tready        tuser: command; tdata: stamp_us, frame_number
//  m_*      out  m_tvalid/m_tready        tdata: query_number, matched_frame, time_gap_us
//  cfg_*    in   cfg_we                   cfg_index, cfg_data
//
// load, clear and unused commands leave the sequencer idle, so s_tready stays high
// a match runs at most ceil(log2(entries+1)) search probes, reads one or two candidate entries, picks the nearer,
// checks the gap limit and makes one table read per probe through the single read port
// the finished result waits in an output register; new requests are taken meanwhile,
// and only the final step of a later match waits for m_tready
// reset clears counters, config and control; the table memory itself is not cleared
module nearest_timestamp_matcher
	import ntm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // stamp_us[39:0], frame_number[71:40]
	input  logic [CMD_W-1:0]     s_tuser,   // command[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // query_number[31:0], matched_frame[63:32], time_gap_us[103:64]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_NEAR_HI,
		ST_NEAR_LO,
		ST_SINGLE,
		ST_PICK,
		ST_LIMIT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [QNUM_W-1:0]  qcount_q;
	logic [QNUM_W-1:0]  qnum_q;
	logic [STAMP_W-1:0] query_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic [CNT_W-1:0]   j_q;
	logic [STAMP_W-1:0] d_hi_q;
	logic [STAMP_W-1:0] d_lo_q;
	logic [FRAME_W-1:0] f_hi_q;
	logic [FRAME_W-1:0] f_lo_q;
	logic [STAMP_W-1:0] gap_q;
	logic [FRAME_W-1:0] frame_q;
	logic               gap_en_q;
	logic [CFG_W-1:0]   gap_limit_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	logic [STAMP_W-1:0] in_stamp;
	logic [FRAME_W-1:0] in_frame;
	cmd_t               in_cmd;
	logic               accept;

	tbl_wr_t            tbl_wr;
	tbl_rd_t            tbl_rd;
	logic [IDX_W-1:0]   rd_addr;

	logic [STAMP_W:0]   sub_rq;
	logic               rd_below;
	logic [STAMP_W-1:0] absd;
	logic [CNT_W-1:0]   mid;
	logic [CNT_W-1:0]   new_lo;
	logic [CNT_W-1:0]   new_hi;
	logic [CNT_W-1:0]   next_mid;
	logic               search_done;
	logic [STAMP_W-1:0] cmp_a;
	logic [STAMP_W-1:0] cmp_b;
	logic               cmp_lt;
	logic               out_free;

	// request unpacking
	assign in_stamp = s_tdata[STAMP_W-1:0];
	assign in_frame = s_tdata[STAMP_W+FRAME_W-1:STAMP_W];
	assign in_cmd   = cmd_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// table write on an accepted load into a table with room
	always_comb begin
		tbl_wr.en    = accept && (in_cmd == CMD_LOAD) && (count_q != CNT_W'(TABLE_DEPTH));
		tbl_wr.addr  = count_q[IDX_W-1:0];
		tbl_wr.stamp = in_stamp;
		tbl_wr.frame = in_frame;
	end

	ntm_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd      (tbl_rd)
	);

	// shared subtractor: entry below query and absolute gap
	assign sub_rq   = {1'b0, tbl_rd.stamp} - {1'b0, query_q};
	assign rd_below = sub_rq[STAMP_W];
	assign absd     = rd_below ? (query_q - tbl_rd.stamp) : sub_rq[STAMP_W-1:0];

	// search step on the probe just read
	assign mid         = lo_q + ((hi_q - lo_q) >> 1);
	assign new_lo      = rd_below ? (mid + CNT_W'(1)) : lo_q;
	assign new_hi      = rd_below ? hi_q : mid;
	assign next_mid    = new_lo + ((new_hi - new_lo) >> 1);
	assign search_done = (new_lo >= new_hi);

	// shared comparator: candidate gaps, then gap limit
	assign cmp_a  = (state_q == ST_PICK) ? d_hi_q : gap_limit_q;
	assign cmp_b  = (state_q == ST_PICK) ? d_lo_q : gap_q;
	assign cmp_lt = (cmp_a < cmp_b);

	// read address select
	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = count_q[CNT_W-1:1];
			end
			ST_SEARCH: begin
				if (!search_done) begin
					rd_addr = next_mid[IDX_W-1:0];
				end else if (new_lo == '0) begin
					rd_addr = '0;
				end else if (new_lo == count_q) begin
					rd_addr = IDX_W'(count_q - CNT_W'(1));
				end else begin
					rd_addr = new_lo[IDX_W-1:0];
				end
			end
			ST_NEAR_HI: begin
				rd_addr = IDX_W'(j_q - CNT_W'(1));
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_en_q    <= 1'b0;
			gap_limit_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAP_EN:    gap_en_q    <= cfg_data[0];
				REG_GAP_LIMIT: gap_limit_q <= cfg_data;
			endcase
		end
	end

	// sequencer with counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			qcount_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// the limit step decides the output valid on its own
			if (m_tvalid_q && m_tready && state_q != ST_LIMIT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_LOAD: begin
								if (tbl_wr.en) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_CLEAR: begin
								count_q  <= '0;
								qcount_q <= '0;
							end
							CMD_MATCH: begin
								qnum_q   <= qcount_q;
								qcount_q <= qcount_q + QNUM_W'(1);
								query_q  <= in_stamp;
								lo_q     <= '0;
								hi_q     <= count_q;
								if (count_q != '0) begin
									state_q <= ST_SEARCH;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SEARCH: begin
					lo_q <= new_lo;
					hi_q <= new_hi;
					if (search_done) begin
						j_q <= new_lo;
						if (new_lo == '0 || new_lo == count_q) begin
							state_q <= ST_SINGLE;
						end else begin
							state_q <= ST_NEAR_HI;
						end
					end
				end
				ST_NEAR_HI: begin
					d_hi_q  <= absd;
					f_hi_q  <= tbl_rd.frame;
					state_q <= ST_NEAR_LO;
				end
				ST_NEAR_LO: begin
					d_lo_q  <= absd;
					f_lo_q  <= tbl_rd.frame;
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					// tie goes to the earlier entry
					if (cmp_lt) begin
						gap_q   <= d_hi_q;
						frame_q <= f_hi_q;
					end else begin
						gap_q   <= d_lo_q;
						frame_q <= f_lo_q;
					end
					state_q <= ST_LIMIT;
				end
				ST_SINGLE: begin
					gap_q   <= absd;
					frame_q <= tbl_rd.frame;
					state_q <= ST_LIMIT;
				end
				ST_LIMIT: begin
					if (out_free) begin
						// a gap over an enabled limit leaves the output empty
						m_tvalid_q <= !(gap_en_q && cmp_lt);
						if (!(gap_en_q && cmp_lt)) begin
							m_tdata_q <= {gap_q, frame_q, qnum_q};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/ntm_checker.sv
// port checker for the nearest timestamp matcher and its bind
`include "nearest_timestamp_matcher_assert.svh"

module ntm_checker
	import ntm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [CMD_W-1:0] s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// a stalled result stays offered
	`NTM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	// a stalled result keeps its payload
	`NTM_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

	// a new result only comes out of a match in progress
	`NTM_ASSERT_NOW(a_out_from_match, clk, arst_n, $rose(m_tvalid), !$past(s_tready), "result without a match in progress")

	// load, clear and unused requests leave the input ready for the next request
	`NTM_ASSERT_NEXT(a_short_cmd, clk, arst_n, s_tvalid && s_tready && (s_tuser != CMD_MATCH), s_tready, "short request held the input")

endmodule

bind nearest_timestamp_matcher ntm_checker u_ntm_checker (.*);
